FILE: rtl/ansi_escape_stripper_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the escape stripper
// Shared concurrent assertion forms; each expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ANSI_ESCAPE_STRIPPER_CORE_ASSERT_SVH
`define ANSI_ESCAPE_STRIPPER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define AES_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define AES_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/aes_pkg.sv
// ----------------------------------------------------------------------------
// aes_pkg
// Byte classes and queue entry type shared by the stripper front and back.
// ----------------------------------------------------------------------------
package aes_pkg;

	// Byte class as seen by the parser
	typedef logic [2:0] byte_class_t;

	localparam byte_class_t CLS_OTHER = 3'd0; // control byte that is dropped
	localparam byte_class_t CLS_PRINT = 3'd1; // printable, CR, LF or TAB
	localparam byte_class_t CLS_ESC   = 3'd2;
	localparam byte_class_t CLS_BEL   = 3'd3;
	localparam byte_class_t CLS_LBRK  = 3'd4;
	localparam byte_class_t CLS_RBRK  = 3'd5;
	localparam byte_class_t CLS_BSL   = 3'd6;
	localparam byte_class_t CLS_PARAM = 3'd7; // digit, ';' or '?'

	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_BEL   = 8'h07;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_RBRK  = 8'h5D;
	localparam logic [7:0] CH_QUES  = 8'h3F;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// One classified byte in the queue
	typedef struct packed {
		byte_class_t cls;
		logic [7:0]  data;
		logic        last;
	} aes_entry_t;

endpackage

FILE: rtl/aes_front.sv
// ----------------------------------------------------------------------------
// aes_front
// Accepts input transactions and registers each byte with its class.
// ----------------------------------------------------------------------------
`include "ansi_escape_stripper_core_assert.svh"

module aes_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] data_byte
	input  logic               s_tlast,
	output logic               push_valid,
	input  logic               push_ready,
	output aes_pkg::aes_entry_t push_entry
);

	logic                  valid_s1;
	logic [7:0]            data_s1;
	logic                  last_s1;
	aes_pkg::byte_class_t  cls_s1;
	aes_pkg::byte_class_t  cls_in;
	logic                  accept;

	// Classify the incoming byte
	always_comb begin
		if (s_tdata == aes_pkg::CH_ESC) begin
			cls_in = aes_pkg::CLS_ESC;
		end else if (s_tdata == aes_pkg::CH_BEL) begin
			cls_in = aes_pkg::CLS_BEL;
		end else if (s_tdata == aes_pkg::CH_LBRK) begin
			cls_in = aes_pkg::CLS_LBRK;
		end else if (s_tdata == aes_pkg::CH_RBRK) begin
			cls_in = aes_pkg::CLS_RBRK;
		end else if (s_tdata == aes_pkg::CH_BSL) begin
			cls_in = aes_pkg::CLS_BSL;
		end else if ((s_tdata >= aes_pkg::CH_ZERO && s_tdata <= aes_pkg::CH_NINE) ||
				s_tdata == aes_pkg::CH_SEMI || s_tdata == aes_pkg::CH_QUES) begin
			cls_in = aes_pkg::CLS_PARAM;
		end else if (s_tdata >= aes_pkg::CH_SPACE || s_tdata == aes_pkg::CH_CR ||
				s_tdata == aes_pkg::CH_LF || s_tdata == aes_pkg::CH_TAB) begin
			cls_in = aes_pkg::CLS_PRINT;
		end else begin
			cls_in = aes_pkg::CLS_OTHER;
		end
	end

	// Take a new transaction whenever the stage is empty or drains this cycle
	assign s_tready = !valid_s1 || push_ready;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Hold payload until the queue takes it
	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
			cls_s1  <= cls_in;
		end
	end

	assign push_valid = valid_s1;
	assign push_entry = '{cls: cls_s1, data: data_s1, last: last_s1};

	`AES_ASSERT_NEXT(a_front_hold, valid_s1 && !push_ready,
		valid_s1 && $stable(data_s1) && $stable(cls_s1) && $stable(last_s1),
		"front stage lost or changed a byte while the queue was full")
	`AES_ASSERT_NOW(a_front_ready, !s_tready, valid_s1,
		"front stalled with an empty stage")
	`AES_ASSERT_NEXT(a_front_cls, accept && s_tdata == aes_pkg::CH_ESC,
		cls_s1 == aes_pkg::CLS_ESC, "escape byte misclassified")

endmodule

FILE: rtl/aes_fifo.sv
// ----------------------------------------------------------------------------
// aes_fifo
// Two-entry queue of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
`include "ansi_escape_stripper_core_assert.svh"

module aes_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  aes_pkg::aes_entry_t push_entry,
	output logic                pop_valid,
	input  logic                pop_ready,
	output aes_pkg::aes_entry_t pop_entry
);

	aes_pkg::aes_entry_t mem_q [2];
	logic                wr_ptr_q;
	logic                rd_ptr_q;
	logic [1:0]          count_q;
	logic                push;
	logic                pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_entry  = mem_q[rd_ptr_q];

	// Store the pushed entry
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	`AES_ASSERT_NOW(a_fifo_bound, 1'b1, count_q != 2'd3, "queue occupancy overflow")
	`AES_ASSERT_NOW(a_fifo_ptrs, count_q == 2'd0 || count_q == 2'd2,
		wr_ptr_q == rd_ptr_q, "queue pointers disagree with occupancy")

endmodule

FILE: rtl/aes_back.sv
// ----------------------------------------------------------------------------
// aes_back
// Runs the escape parser on classified bytes and registers each result.
// ----------------------------------------------------------------------------
`include "ansi_escape_stripper_core_assert.svh"

module aes_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  aes_pkg::aes_entry_t pop_entry,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,   // [7:0] out_byte
	output logic                m_tuser,   // [0] keep
	output logic                m_tlast
);

	localparam logic [2:0] MODE_NORMAL  = 3'd0;
	localparam logic [2:0] MODE_ESC     = 3'd1;
	localparam logic [2:0] MODE_CSI     = 3'd2;
	localparam logic [2:0] MODE_OSC     = 3'd3;
	localparam logic [2:0] MODE_OSC_ESC = 3'd4;

	logic [2:0] mode_q;
	logic [2:0] mode_next;
	logic       keep;
	logic       pop;
	logic       valid_q;
	logic [7:0] data_q;
	logic       keep_q;
	logic       last_q;

	// Decide keep and next mode for the byte at the queue head
	always_comb begin
		keep      = 1'b0;
		mode_next = MODE_NORMAL;
		unique case (mode_q)
			MODE_ESC: begin
				if (pop_entry.cls == aes_pkg::CLS_LBRK) begin
					mode_next = MODE_CSI;
				end else if (pop_entry.cls == aes_pkg::CLS_RBRK) begin
					mode_next = MODE_OSC;
				end
			end
			MODE_CSI: begin
				if (pop_entry.cls == aes_pkg::CLS_PARAM) begin
					mode_next = MODE_CSI;
				end
			end
			MODE_OSC: begin
				if (pop_entry.cls == aes_pkg::CLS_ESC) begin
					mode_next = MODE_OSC_ESC;
				end else if (pop_entry.cls != aes_pkg::CLS_BEL) begin
					mode_next = MODE_OSC;
				end
			end
			MODE_OSC_ESC: begin
				if (pop_entry.cls == aes_pkg::CLS_ESC) begin
					mode_next = MODE_OSC_ESC;
				end else if (pop_entry.cls != aes_pkg::CLS_BSL &&
						pop_entry.cls != aes_pkg::CLS_BEL) begin
					mode_next = MODE_OSC;
				end
			end
			default: begin
				if (pop_entry.cls == aes_pkg::CLS_ESC) begin
					mode_next = MODE_ESC;
				end else begin
					case (pop_entry.cls) inside
						aes_pkg::CLS_PRINT, aes_pkg::CLS_LBRK, aes_pkg::CLS_RBRK,
						aes_pkg::CLS_BSL, aes_pkg::CLS_PARAM: keep = 1'b1;
						default: keep = 1'b0;
					endcase
				end
			end
		endcase
	end

	// Pop whenever the output register is free or being taken
	assign pop_ready = !valid_q || m_tready;
	assign pop       = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NORMAL;
			valid_q <= 1'b0;
		end else begin
			if (pop_ready) begin
				valid_q <= pop_valid;
			end
			if (pop) begin
				mode_q <= pop_entry.last ? MODE_NORMAL : mode_next;
			end
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= pop_entry.data;
			keep_q <= keep;
			last_q <= pop_entry.last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = keep_q;
	assign m_tlast  = last_q;

	`AES_ASSERT_NEXT(a_back_last, pop && pop_entry.last, mode_q == MODE_NORMAL,
		"parser not back in normal mode after last byte")
	`AES_ASSERT_NOW(a_back_keep, pop && keep, mode_q != MODE_ESC && mode_q != MODE_CSI &&
		mode_q != MODE_OSC && mode_q != MODE_OSC_ESC, "byte kept inside a sequence")
	`AES_ASSERT_NOW(a_back_mode, 1'b1, mode_q <= MODE_OSC_ESC, "unused parser mode")

endmodule

FILE: rtl/ansi_escape_stripper_core.sv
// One byte of terminal output enters per transaction on the s_ side and one
// result leaves per transaction on the m_ side: the byte itself in m_tdata,
// a keep flag in m_tuser (1 when the byte belongs in the cleaned text) and the
// end-of-buffer mark in m_tlast. CSI and OSC sequences and two-byte escapes
// are marked as dropped; the parser returns to normal text after every byte
// marked last. The block sustains one byte per clock cycle while the output
// is not stalled; the mode register in the back part updates once per byte
// and sets that rate. An accepted byte passes through the front register,
// the queue and the result register on its way to the output, and either
// side may stall without blocking the other until the two-entry queue fills.
// ----------------------------------------------------------------------------
// ansi_escape_stripper_core
// Top level: classifying front, queue, and parsing back end.
// ----------------------------------------------------------------------------
module ansi_escape_stripper_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,   // end_of_buffer
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tuser,   // [0] keep
	output logic       m_tlast    // out_last
);

	logic                push_valid;
	logic                push_ready;
	aes_pkg::aes_entry_t push_entry;
	logic                pop_valid;
	logic                pop_ready;
	aes_pkg::aes_entry_t pop_entry;

	aes_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	aes_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	aes_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
